// ----- rtl/blsk_pkg.sv -----
// Shared types, request codes and fixed-point helpers for the skinning block.
package blsk_pkg;

    localparam logic [2:0] REQ_XFORM  = 3'd0;
    localparam logic [2:0] REQ_WEIGHT = 3'd1;
    localparam logic [2:0] REQ_START  = 3'd2;
    localparam logic [2:0] REQ_DELTA  = 3'd3;
    localparam logic [2:0] REQ_INFL   = 3'd4;

    localparam logic [3:0] XF_ELEMS = 4'd12;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_XFORM,
        CMD_WEIGHT,
        CMD_START,
        CMD_DELTA,
        CMD_INFL
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               joint_ok;
        logic [7:0]         slot;
        logic [3:0]         element;
        logic signed [31:0] value;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [16:0]        skin_weight;
        logic               last;
    } item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DLT_MUL,
        S_DLT_ADD,
        S_INF_RUN,
        S_EMIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int n);
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (n - 1);
        return (v + bias) >>> n;
    endfunction

endpackage

// ----- rtl/blsk_front.sv -----
// Front end: accepts input transfers, classifies them and queues them for the back end.
module blsk_front #(
    parameter int JOINT_COUNT = 256,
    parameter int SHAPE_COUNT = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [7:0]         slot,
    input  logic [3:0]         element,
    input  logic signed [31:0] value,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic [16:0]        skin_weight,
    input  logic               last,
    output blsk_pkg::item_t    q_item,
    output logic               q_valid,
    input  logic               q_ready
);

    blsk_pkg::item_t q_mem [2];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;
    logic            joint_ok;
    logic            shape_ok;
    blsk_pkg::item_t cls;

    assign joint_ok = 32'(slot) < JOINT_COUNT;
    assign shape_ok = 32'(slot) < SHAPE_COUNT;

    always_comb begin
        cls.joint_ok    = joint_ok;
        cls.slot        = slot;
        cls.element     = element;
        cls.value       = value;
        cls.px          = px;
        cls.py          = py;
        cls.pz          = pz;
        cls.skin_weight = skin_weight;
        cls.last        = last;
        unique case (req_type)
            blsk_pkg::REQ_XFORM: begin
                cls.cmd = (joint_ok && element < blsk_pkg::XF_ELEMS) ?
                          blsk_pkg::CMD_XFORM : blsk_pkg::CMD_NOP;
            end
            blsk_pkg::REQ_WEIGHT: cls.cmd = shape_ok ? blsk_pkg::CMD_WEIGHT : blsk_pkg::CMD_NOP;
            blsk_pkg::REQ_START:  cls.cmd = blsk_pkg::CMD_START;
            blsk_pkg::REQ_DELTA:  cls.cmd = shape_ok ? blsk_pkg::CMD_DELTA : blsk_pkg::CMD_NOP;
            blsk_pkg::REQ_INFL:   cls.cmd = blsk_pkg::CMD_INFL;
            default:              cls.cmd = blsk_pkg::CMD_NOP;
        endcase
    end

    assign in_ready = count_reg != 2'd2;
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = q_mem[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

endmodule

// ----- rtl/blsk_back.sv -----
// Back end: transform and weight stores, blend-shape and influence arithmetic, result register.
module blsk_back #(
    parameter int JOINT_COUNT    = 256,
    parameter int SHAPE_COUNT    = 256,
    parameter int MAX_INFLUENCES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  blsk_pkg::item_t    q_item,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    localparam int TAW  = $clog2(JOINT_COUNT * 12);
    localparam int WAW  = (SHAPE_COUNT > 1) ? $clog2(SHAPE_COUNT) : 1;
    localparam int CNTW = $clog2(MAX_INFLUENCES + 1);

    logic signed [31:0] xf_mem [JOINT_COUNT * 12];
    logic signed [31:0] wt_mem [SHAPE_COUNT];

    blsk_pkg::state_t   state_reg;
    blsk_pkg::state_t   state_next;
    blsk_pkg::item_t    cur_reg;
    logic [8:0]         blend_count_reg;
    logic signed [31:0] rest_reg [3];
    logic signed [63:0] acc_reg [3];
    logic               stopped_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [1:0]         r_reg;
    logic signed [63:0] dprod_reg;
    logic signed [31:0] wt_rdata_reg;

    logic [3:0]         k_reg;
    logic               b_vld_reg;
    logic [3:0]         b_k_reg;
    logic signed [31:0] xf_rdata_reg;
    logic               c_vld_reg;
    logic [3:0]         c_k_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] s_reg;
    logic               d_vld_reg;
    logic [1:0]         d_r_reg;
    logic signed [63:0] srow_reg;
    logic               e_vld_reg;
    logic [1:0]         e_r_reg;
    logic signed [63:0] wprod_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_z_reg;

    logic               pop;
    logic               xf_we;
    logic               wt_we;
    logic               dlt_ok;
    logic               inf_apply;
    logic               inf_go;
    logic               issuing;
    logic               drained;
    logic               out_free;
    logic               emit;
    logic [15:0]        xf_base;
    logic [15:0]        xf_waddr;
    logic [15:0]        xf_raddr;
    logic [WAW-1:0]     wt_idx;
    logic signed [31:0] p_sel;
    logic signed [31:0] rest_b;
    logic signed [63:0] term;
    logic signed [63:0] ssum;
    logic signed [63:0] qfull;
    logic signed [47:0] qv;
    logic signed [63:0] dsum;

    assign xf_base  = {5'd0, cur_reg.slot, 3'd0} + {6'd0, cur_reg.slot, 2'd0};
    assign xf_waddr = xf_base + {12'd0, cur_reg.element};
    assign xf_raddr = xf_base + {12'd0, k_reg};
    assign wt_idx   = WAW'({8'd0, cur_reg.slot});
    assign out_free = !out_valid_reg || out_ready;
    assign dlt_ok   = {1'b0, cur_reg.slot} < blend_count_reg;
    assign inf_apply = !stopped_reg && cur_reg.skin_weight != 17'd0
                       && 32'(cnt_reg) < MAX_INFLUENCES;
    assign inf_go   = inf_apply && cur_reg.joint_ok;
    assign issuing  = state_reg == blsk_pkg::S_INF_RUN && k_reg != blsk_pkg::XF_ELEMS;
    assign drained  = k_reg == blsk_pkg::XF_ELEMS && !b_vld_reg && !c_vld_reg
                      && !d_vld_reg && !e_vld_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            blsk_pkg::S_IDLE: begin
                if (q_valid) begin
                    state_next = blsk_pkg::S_DECODE;
                end
            end
            blsk_pkg::S_DECODE: begin
                state_next = blsk_pkg::S_IDLE;
                if (cur_reg.cmd == blsk_pkg::CMD_DELTA && dlt_ok) begin
                    state_next = blsk_pkg::S_DLT_MUL;
                end else if (cur_reg.cmd == blsk_pkg::CMD_INFL) begin
                    if (inf_go) begin
                        state_next = blsk_pkg::S_INF_RUN;
                    end else if (cur_reg.last) begin
                        state_next = blsk_pkg::S_EMIT;
                    end
                end
            end
            blsk_pkg::S_DLT_MUL: state_next = blsk_pkg::S_DLT_ADD;
            blsk_pkg::S_DLT_ADD: begin
                if (r_reg == 2'd2) begin
                    state_next = blsk_pkg::S_IDLE;
                end else begin
                    state_next = blsk_pkg::S_DLT_MUL;
                end
            end
            blsk_pkg::S_INF_RUN: begin
                if (drained) begin
                    state_next = cur_reg.last ? blsk_pkg::S_EMIT : blsk_pkg::S_IDLE;
                end
            end
            blsk_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = blsk_pkg::S_IDLE;
                end
            end
            default: state_next = blsk_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop   = 1'b0;
        xf_we = 1'b0;
        wt_we = 1'b0;
        emit  = 1'b0;
        unique case (state_reg)
            blsk_pkg::S_IDLE:   pop = q_valid;
            blsk_pkg::S_DECODE: begin
                xf_we = cur_reg.cmd == blsk_pkg::CMD_XFORM;
                wt_we = cur_reg.cmd == blsk_pkg::CMD_WEIGHT;
            end
            blsk_pkg::S_EMIT:   emit = out_free;
            default: ;
        endcase
    end

    assign q_ready = pop;

    // stores
    always_ff @(posedge aclk) begin
        if (xf_we) begin
            xf_mem[xf_waddr[TAW-1:0]] <= cur_reg.value;
        end
        if (issuing) begin
            xf_rdata_reg <= xf_mem[xf_raddr[TAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_mem[wt_idx] <= cur_reg.value;
        end
        wt_rdata_reg <= wt_mem[wt_idx];
    end

    always_comb begin
        case (r_reg)
            2'd0:    p_sel = cur_reg.px;
            2'd1:    p_sel = cur_reg.py;
            default: p_sel = cur_reg.pz;
        endcase
        case (b_k_reg[1:0])
            2'd0:    rest_b = rest_reg[0];
            2'd1:    rest_b = rest_reg[1];
            default: rest_b = rest_reg[2];
        endcase
        term  = (c_k_reg[1:0] == 2'd3) ? prod_reg : (prod_reg >>> 8);
        ssum  = ((c_k_reg[1:0] == 2'd0) ? 64'sd0 : s_reg) + term;
        qfull = blsk_pkg::round_shift(srow_reg, 16);
        qv    = qfull[47:0];
        dsum  = 64'(rest_reg[r_reg]) + blsk_pkg::round_shift(dprod_reg, 24);
    end

    // influence pipeline datapath: read, multiply, row sum, weight, accumulate
    always_ff @(posedge aclk) begin
        if (b_vld_reg) begin
            if (b_k_reg[1:0] == 2'd3) begin
                prod_reg <= 64'(xf_rdata_reg) <<< 8;
            end else begin
                prod_reg <= 64'(xf_rdata_reg) * 64'(rest_b);
            end
        end
        c_k_reg <= b_k_reg;
        b_k_reg <= k_reg;
        if (c_vld_reg) begin
            s_reg <= ssum;
            if (c_k_reg[1:0] == 2'd3) begin
                srow_reg <= ssum;
                d_r_reg  <= c_k_reg[3:2];
            end
        end
        if (d_vld_reg) begin
            wprod_reg <= 64'(qv) * 64'($signed({1'b0, cur_reg.skin_weight}));
            e_r_reg   <= d_r_reg;
        end
        if (state_reg == blsk_pkg::S_DLT_MUL) begin
            dprod_reg <= 64'(wt_rdata_reg) * 64'(p_sel);
        end
        if (pop) begin
            cur_reg <= q_item;
        end
        if (emit) begin
            out_x_reg <= blsk_pkg::sat32(blsk_pkg::round_shift(acc_reg[0], 16));
            out_y_reg <= blsk_pkg::sat32(blsk_pkg::round_shift(acc_reg[1], 16));
            out_z_reg <= blsk_pkg::sat32(blsk_pkg::round_shift(acc_reg[2], 16));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= blsk_pkg::S_IDLE;
            blend_count_reg <= 9'd0;
            rest_reg        <= '{default: 32'sd0};
            acc_reg         <= '{default: 64'sd0};
            stopped_reg     <= 1'b0;
            cnt_reg         <= '0;
            r_reg           <= 2'd0;
            k_reg           <= blsk_pkg::XF_ELEMS;
            b_vld_reg       <= 1'b0;
            c_vld_reg       <= 1'b0;
            d_vld_reg       <= 1'b0;
            e_vld_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                blend_count_reg <= cfg_wdata;
            end
            b_vld_reg <= issuing;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg && c_k_reg[1:0] == 2'd3;
            e_vld_reg <= d_vld_reg;
            if (issuing) begin
                k_reg <= k_reg + 4'd1;
            end
            if (e_vld_reg) begin
                acc_reg[e_r_reg] <= acc_reg[e_r_reg] + wprod_reg;
            end
            if (state_reg == blsk_pkg::S_DECODE) begin
                r_reg <= 2'd0;
                unique case (cur_reg.cmd)
                    blsk_pkg::CMD_START: begin
                        rest_reg[0] <= cur_reg.px;
                        rest_reg[1] <= cur_reg.py;
                        rest_reg[2] <= cur_reg.pz;
                        acc_reg     <= '{default: 64'sd0};
                        stopped_reg <= 1'b0;
                        cnt_reg     <= '0;
                    end
                    blsk_pkg::CMD_INFL: begin
                        if (!stopped_reg && cur_reg.skin_weight == 17'd0) begin
                            stopped_reg <= 1'b1;
                        end
                        if (inf_apply) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        if (inf_go) begin
                            k_reg <= 4'd0;
                        end
                    end
                    default: ;
                endcase
            end
            if (state_reg == blsk_pkg::S_DLT_ADD) begin
                rest_reg[r_reg] <= blsk_pkg::sat32(dsum);
                r_reg           <= r_reg + 2'd1;
            end
            if (emit) begin
                stopped_reg   <= 1'b1;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

endmodule

// ----- rtl/blend_shape_linear_skinning.sv -----
// Top level of the fixed-point linear blend skinning block with blend shapes.
//
// Input stream (s_*): one request per transfer; s_tuser carries the request type
// (load transform element, load blend weight, vertex start, shape delta, joint
// influence), s_tlast marks the final influence of a vertex. Output stream (m_*)
// carries one skinned Q16.16 position per vertex, on the influence marked last.
// cfg_we/cfg_wdata set the number of blend weights in use.
// A two-entry queue decouples intake from execution; input is taken while a
// result waits in the output register.
// The back-end sequencer handles one item at a time: a shape delta does one
// 32x32 multiply per axis, then add and saturate; an applied influence makes
// 12 transform reads from the single store port through a five-stage
// multiply/accumulate pipeline; an emit then loads the output register.
// Reset clears control state, the rest position, sums and blend count; the
// transform and weight stores hold whatever was written. If m_tready is low the
// result holds; the back end keeps working until the next emit, then the queue
// fills and s_tready drops.
module blend_shape_linear_skinning #(
    parameter int JOINT_COUNT    = 256,
    parameter int SHAPE_COUNT    = 256,
    parameter int MAX_INFLUENCES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // slot, element, value, px, py, pz, skin_weight, zero pad
    input  logic [2:0]   s_tuser,   // req_type
    input  logic         s_tlast,   // last_influence
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_x, out_y, out_z
    input  logic         cfg_we,
    input  logic [8:0]   cfg_wdata
);

    blsk_pkg::item_t    q_item;
    logic               q_valid;
    logic               q_ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    blsk_front #(
        .JOINT_COUNT(JOINT_COUNT),
        .SHAPE_COUNT(SHAPE_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .req_type    (s_tuser),
        .slot        (s_tdata[7:0]),
        .element     (s_tdata[11:8]),
        .value       (s_tdata[43:12]),
        .px          (s_tdata[75:44]),
        .py          (s_tdata[107:76]),
        .pz          (s_tdata[139:108]),
        .skin_weight (s_tdata[156:140]),
        .last        (s_tlast),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .q_ready     (q_ready)
    );

    blsk_back #(
        .JOINT_COUNT   (JOINT_COUNT),
        .SHAPE_COUNT   (SHAPE_COUNT),
        .MAX_INFLUENCES(MAX_INFLUENCES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

    assign m_tdata = {out_z, out_y, out_x};

endmodule

// ----- rtl/blsk_checker.sv -----
// Port-level checker for the skinning block and its bind.
module blsk_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [159:0] s_tdata,
    input logic [2:0]   s_tuser,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic         cfg_we,
    input logic [8:0]   cfg_wdata
);

    // result held under backpressure
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_rst_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // a result needs a queued item to get through decode first
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid || !$rose(m_tvalid))
        else $error("result appeared without any transfer");

endmodule

bind blend_shape_linear_skinning blsk_checker u_blsk_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the fixed-point linear blend skinning block.
module tb;

    localparam int JOINTS = 256;
    localparam int SHAPES = 256;
    localparam int MAX_INFL = 8;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         cfg_we;
    logic [8:0]   cfg_wdata;

    blend_shape_linear_skinning i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    typedef struct {
        logic [2:0]         kind;
        logic [7:0]         slot;
        logic [3:0]         element;
        logic signed [31:0] value;
        logic signed [31:0] px, py, pz;
        logic [16:0]        skin_weight;
        logic               last;
    } req_s;

    typedef struct {
        logic signed [31:0] x, y, z;
    } pos_s;

    typedef struct {
        req_s r;
        bit   has_pos;
        pos_s pos;
    } row_s;

    // predictor state
    logic signed [31:0] xf_mem [JOINTS*12];
    logic signed [31:0] bw_mem [SHAPES];
    bit                 xf_set [JOINTS];
    bit                 bw_set [SHAPES];
    logic signed [31:0] rest [3];
    logic signed [63:0] acc [3];
    bit                 stopped;
    int                 n_applied;
    int                 shapes_used;

    pos_s skinned_q[$];
    int   errors;
    int   send_idle, recv_idle;

    function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int n);
        return v >>> n;
    endfunction

    function automatic logic signed [63:0] rnd_shr(logic signed [63:0] v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic predict_skin(input req_s r);
        logic signed [63:0] s, q, d;
        logic signed [31:0] p [3];
        pos_s o;
        p[0] = r.px; p[1] = r.py; p[2] = r.pz;
        case (r.kind)
            blsk_pkg::REQ_XFORM:
                if (r.element < blsk_pkg::XF_ELEMS) xf_mem[r.slot*12 + r.element] = r.value;
            blsk_pkg::REQ_WEIGHT: bw_mem[r.slot] = r.value;
            blsk_pkg::REQ_START: begin
                for (int i = 0; i < 3; i++) begin rest[i] = p[i]; acc[i] = 0; end
                stopped = 0;
                n_applied = 0;
            end
            blsk_pkg::REQ_DELTA: if (r.slot < shapes_used) begin
                for (int i = 0; i < 3; i++) begin
                    d = rnd_shr(64'(bw_mem[r.slot]) * 64'(p[i]), 24);
                    rest[i] = clip32(64'(rest[i]) + d);
                end
            end
            blsk_pkg::REQ_INFL: begin
                if (!stopped) begin
                    if (r.skin_weight == 0) stopped = 1;
                    else if (n_applied < MAX_INFL) begin
                        n_applied++;
                        for (int i = 0; i < 3; i++) begin
                            s = 64'(xf_mem[r.slot*12 + i*4 + 3]) * 256;
                            for (int c = 0; c < 3; c++)
                                s += floor_shr(64'(xf_mem[r.slot*12 + i*4 + c]) * 64'(rest[c]), 8);
                            q = rnd_shr(s, 16);
                            acc[i] += q * $signed({47'd0, r.skin_weight});
                        end
                    end
                end
                if (r.last) begin
                    stopped = 1;
                    o.x = clip32(rnd_shr(acc[0], 16));
                    o.y = clip32(rnd_shr(acc[1], 16));
                    o.z = clip32(rnd_shr(acc[2], 16));
                    skinned_q.push_back(o);
                end
            end
            default: ;
        endcase
    endtask

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver and checker
    always @(posedge aclk) begin
        pos_s e;
        if (aresetn && m_tvalid && m_tready) begin
            if (skinned_q.size() == 0) begin
                $error("unexpected output transfer %h", m_tdata);
                errors++;
            end else begin
                e = skinned_q.pop_front();
                if (m_tdata[31:0] !== e.x) begin
                    $error("out_x expected %0d actual %0d", e.x, $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tdata[63:32] !== e.y) begin
                    $error("out_y expected %0d actual %0d", e.y, $signed(m_tdata[63:32]));
                    errors++;
                end
                if (m_tdata[95:64] !== e.z) begin
                    $error("out_z expected %0d actual %0d", e.z, $signed(m_tdata[95:64]));
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_req(input req_s r);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= r.kind;
        s_tlast  <= r.last;
        s_tdata  <= {3'd0, r.skin_weight, r.pz, r.py, r.px, r.value, r.element, r.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_skin(r);
        if (r.kind == blsk_pkg::REQ_XFORM && r.element < blsk_pkg::XF_ELEMS) xf_set[r.slot] = 1;
        if (r.kind == blsk_pkg::REQ_WEIGHT) bw_set[r.slot] = 1;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (skinned_q.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic set_shapes(input int n);
        drain();
        cfg_we <= 1;
        cfg_wdata <= 9'(n);
        @(negedge aclk);
        cfg_we <= 0;
        shapes_used = n;
    endtask

    function automatic req_s mk(logic [2:0] k, logic [7:0] sl, logic [3:0] el,
                                logic signed [31:0] v, logic signed [31:0] x,
                                logic signed [31:0] y, logic signed [31:0] z,
                                logic [16:0] w, logic l);
        req_s r;
        r.kind = k; r.slot = sl; r.element = el; r.value = v;
        r.px = x; r.py = y; r.pz = z; r.skin_weight = w; r.last = l;
        return r;
    endfunction

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(131072)) - 32'sd65536);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_q824();
        case ($urandom_range(3))
            0: return 32'sh01000000;
            1: return rnd32();
            default: return $signed(32'($urandom_range(33554432)) - 32'sd16777216);
        endcase
    endfunction

    // load a full transform for one joint
    task automatic load_joint(input logic [7:0] j);
        for (int e = 0; e < 12; e++)
            send_req(mk(blsk_pkg::REQ_XFORM, j, 4'(e), rnd_q824(), rnd32(), rnd32(), rnd32(),
                        17'($urandom()), 1'($urandom())));
    endtask

    task automatic random_vertex();
        int nd, ni, k;
        logic [7:0] j;
        logic [16:0] w;
        send_req(mk(blsk_pkg::REQ_START, 8'($urandom()), 4'($urandom()), rnd32(), rnd32(),
                    rnd32(), rnd32(), 17'($urandom()), 1'($urandom())));
        nd = $urandom_range(3);
        for (int i = 0; i < nd; i++) begin
            do k = $urandom_range(255); while (!bw_set[k]);
            send_req(mk(blsk_pkg::REQ_DELTA, 8'(k), 4'($urandom()), rnd32(), rnd32(), rnd32(),
                        rnd32(), 17'($urandom()), 1'($urandom())));
        end
        ni = $urandom_range(1, 11);
        for (int i = 0; i < ni; i++) begin
            do j = 8'($urandom()); while (!xf_set[j]);
            case ($urandom_range(9))
                0: w = 0;
                1: w = 17'd65536;
                2: w = 17'h1ffff;
                default: w = 17'($urandom_range(65536));
            endcase
            send_req(mk(blsk_pkg::REQ_INFL, j, 4'($urandom()), rnd32(), rnd32(), rnd32(),
                        rnd32(), w, i == ni - 1));
        end
        if ($urandom_range(9) == 0)
            send_req(mk(blsk_pkg::REQ_INFL, j, 0, 0, 0, 0, 0, 17'd100, 1));
    endtask

    row_s tbl[$];
    row_s rw;
    pos_s zero_pos;

    initial begin
        errors = 0; stopped = 0; n_applied = 0; shapes_used = 0;
        for (int i = 0; i < 3; i++) begin rest[i] = 0; acc[i] = 0; end
        foreach (xf_mem[i]) xf_mem[i] = 0;
        foreach (bw_mem[i]) bw_mem[i] = 0;
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0; s_tlast = 0;
        cfg_we = 0; cfg_wdata = 0; m_tready = 0;
        send_idle = 9; recv_idle = 71;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        zero_pos.x = 0; zero_pos.y = 0; zero_pos.z = 0;
        // directed table; has_pos rows carry an expected output known up front
        rw.has_pos = 0;
        rw.r = mk(blsk_pkg::REQ_INFL, 8'd0, 0, 0, 0, 0, 0, 17'd0, 1);
        rw.has_pos = 1; rw.pos = zero_pos; tbl.push_back(rw);  // sums are zero after reset
        rw.has_pos = 0;
        for (int e = 0; e < 12; e++) begin
            rw.r = mk(blsk_pkg::REQ_XFORM, 8'd255, 4'(e),
                      (e % 5 == 0) ? 32'sh01000000 : 32'sh7fffffff, 0, 0, 0, 0, 0);
            tbl.push_back(rw);
        end
        rw.r = mk(blsk_pkg::REQ_XFORM, 8'd255, 4'd15, 32'sh80000000, 0, 0, 0, 0, 0);
        tbl.push_back(rw);
        rw.r = mk(blsk_pkg::REQ_WEIGHT, 8'd255, 0, 32'sh80000000, 0, 0, 0, 0, 0);
        tbl.push_back(rw);
        rw.r = mk(blsk_pkg::REQ_WEIGHT, 8'd0, 0, 32'sh01000000, 0, 0, 0, 0, 0);
        tbl.push_back(rw);
        rw.r = mk(blsk_pkg::REQ_START, 8'd0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh00010000,
                  0, 1); tbl.push_back(rw);
        rw.r = mk(blsk_pkg::REQ_DELTA, 8'd0, 0, 0, 32'sh7fffffff, 32'sh80000000, 1, 0, 0);
        tbl.push_back(rw);  // ignored while no blend weight is in use
        rw.r = mk(blsk_pkg::REQ_INFL, 8'd255, 0, 0, 0, 0, 0, 17'd65536, 0); tbl.push_back(rw);
        rw.r = mk(blsk_pkg::REQ_INFL, 8'd255, 0, 0, 0, 0, 0, 17'h1ffff, 0); tbl.push_back(rw);
        rw.r = mk(blsk_pkg::REQ_INFL, 8'd255, 0, 0, 0, 0, 0, 17'd0, 0); tbl.push_back(rw);
        rw.r = mk(blsk_pkg::REQ_INFL, 8'd255, 0, 0, 0, 0, 0, 17'd1, 1); tbl.push_back(rw);
        rw.r = mk(blsk_pkg::REQ_INFL, 8'd255, 0, 0, 0, 0, 0, 17'd1, 1); tbl.push_back(rw);
        rw.r = mk(3'd7, 8'd255, 4'd15, -1, -1, -1, -1, 17'h1ffff, 1); tbl.push_back(rw);
        rw.r = mk(3'd5, 8'd0, 0, 0, 0, 0, 0, 0, 1); tbl.push_back(rw);

        foreach (tbl[i]) begin
            if (tbl[i].has_pos) begin
                predict_skin(tbl[i].r);
                skinned_q[skinned_q.size()-1] = tbl[i].pos;
                // undo the double prediction: state advance only
                send_req_nopredict(tbl[i].r);
            end else send_req(tbl[i].r);
        end

        set_shapes(256);
        rw.r = mk(blsk_pkg::REQ_START, 0, 0, 0, 32'sh00010000, 32'sh00020000, 32'sh00030000,
                  0, 0);
        send_req(rw.r);
        send_req(mk(blsk_pkg::REQ_DELTA, 8'd0, 0, 0, 32'sh7fffffff, 32'sh80000000,
                    32'sh7fffffff, 0, 1));
        send_req(mk(blsk_pkg::REQ_DELTA, 8'd255, 0, 0, 32'sh7fffffff, 32'sh7fffffff,
                    32'sh80000000, 0, 0));
        for (int i = 0; i < 10; i++)
            send_req(mk(blsk_pkg::REQ_INFL, 8'd255, 0, 0, 0, 0, 0, 17'd65536, i == 9));

        // load 16 joints and 8 shape weights; random vertices read only loaded entries
        for (int j = 0; j < 16; j++) load_joint(8'(j * 16 + $urandom_range(15)));
        for (int k = 0; k < 8; k++)
            send_req(mk(blsk_pkg::REQ_WEIGHT, 8'($urandom()), 4'($urandom()), rnd_q824(),
                        rnd32(), rnd32(), rnd32(), 17'($urandom()), 1'($urandom())));

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle = 71; recv_idle = 9; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            set_shapes(ph == 0 ? 0 : (ph == 1 ? $urandom_range(1, 255) : 256));
            for (int v = 0; v < 40; v++) begin
                if ($urandom_range(7) == 0) load_joint(8'($urandom()));
                if ($urandom_range(7) == 0)
                    send_req(mk(blsk_pkg::REQ_WEIGHT, 8'($urandom()), 0, rnd_q824(),
                                0, 0, 0, 0, 0));
                if ($urandom_range(15) == 0)
                    send_req(mk(3'($urandom_range(5, 7)), 8'($urandom()), 4'($urandom()),
                                rnd32(), rnd32(), rnd32(), rnd32(), 17'($urandom()), 1));
                random_vertex();
                if (v == 30) drain();
            end
        end

        drain();
        if (errors == 0 && skinned_q.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_req_nopredict(input req_s r);
        s_tvalid <= 1;
        s_tuser  <= r.kind;
        s_tlast  <= r.last;
        s_tdata  <= {3'd0, r.skin_weight, r.pz, r.py, r.px, r.value, r.element, r.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask
endmodule
